### rtl/bidsc_pkg.sv
package bidsc_pkg;

    localparam int unsigned CNT_W = 7;
    localparam int unsigned KEY_W = 32;

    localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    typedef struct packed {
        logic [1:0]              op;
        logic signed [KEY_W-1:0] key;
    } t_in_word;

    typedef struct packed {
        logic             success;
        logic [CNT_W-1:0] entry_count;
    } t_out_word;

    typedef struct packed {
        logic load;
        logic issue;
        logic shift;
        logic ins;
        logic dec;
        logic set_ok;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       full;
        logic       hit;
        logic       drained;
        logic       out_free;
    } t_dp_status;

endpackage

### rtl/bidsc_ram.sv
module bidsc_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/bidsc_dp.sv
module bidsc_dp #(
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  bidsc_pkg::t_in_word      i_in_data,
    input  logic                     i_cfg_we,
    input  logic [bidsc_pkg::CNT_W-1:0] i_cfg_wdata,
    input  logic                     i_out_ready,
    input  bidsc_pkg::t_dp_cmd       i_cmd,
    output bidsc_pkg::t_dp_status    o_status,
    output logic                     o_out_valid,
    output bidsc_pkg::t_out_word     o_out_data
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [10:0] DEPTH_W = 11'(DEPTH);

    logic [bidsc_pkg::CNT_W-1:0] r_cap;
    logic [bidsc_pkg::CNT_W-1:0] r_count;
    logic [bidsc_pkg::CNT_W-1:0] r_ptr;
    logic [bidsc_pkg::CNT_W-1:0] r_pidx;
    logic                        r_pv;
    logic [1:0]                  r_op;
    logic [bidsc_pkg::KEY_W-1:0] r_key;
    logic                        r_ok;
    logic                        r_out_valid;
    bidsc_pkg::t_out_word        r_out;

    logic                        issue;
    logic                        more;
    logic                        we;
    logic [AW-1:0]               waddr;
    logic [bidsc_pkg::KEY_W-1:0] wdata;
    logic [bidsc_pkg::KEY_W-1:0] rdata;
    logic [bidsc_pkg::CNT_W-1:0] shift_idx;

    function automatic logic [AW-1:0] to_addr(input logic [bidsc_pkg::CNT_W-1:0] v);
        logic [AW+bidsc_pkg::CNT_W-1:0] w;
        w = {{AW{1'b0}}, v};
        return w[AW-1:0];
    endfunction

    assign more      = (r_ptr < r_count);
    assign issue     = i_cmd.issue && more;
    assign shift_idx = r_pidx - 7'd1;

    always_comb begin
        we    = 1'b0;
        waddr = to_addr(r_count);
        wdata = r_key;
        if (i_cmd.ins) begin
            we = 1'b1;
        end else if (i_cmd.shift && r_pv) begin
            we    = 1'b1;
            waddr = to_addr(shift_idx);
            wdata = rdata;
        end
    end

    bidsc_ram #(
        .WIDTH (bidsc_pkg::KEY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (to_addr(r_ptr)),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= bidsc_pkg::CAP_RESET;
            r_count     <= '0;
            r_ptr       <= '0;
            r_pv        <= 1'b0;
            r_ok        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (i_cmd.load) begin
                r_ptr <= '0;
                r_pv  <= 1'b0;
                r_ok  <= 1'b0;
            end else begin
                r_pv <= issue;
                if (issue) begin
                    r_ptr <= r_ptr + 7'd1;
                end
                if (i_cmd.set_ok) begin
                    r_ok <= 1'b1;
                end
            end
            if (i_cmd.ins) begin
                r_count <= r_count + 7'd1;
            end else if (i_cmd.dec) begin
                r_count <= r_count - 7'd1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_in_data.op;
            r_key <= $unsigned(i_in_data.key);
        end
        if (issue) begin
            r_pidx <= r_ptr;
        end
        if (i_cmd.emit) begin
            r_out.success     <= r_ok;
            r_out.entry_count <= r_count;
        end
    end

    assign o_status.op       = r_op;
    assign o_status.full     = ({4'b0, r_count} >= {4'b0, r_cap}) ||
                               ({4'b0, r_count} >= DEPTH_W);
    assign o_status.hit      = r_pv && (rdata == r_key);
    assign o_status.drained  = !r_pv && !more;
    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### rtl/bidsc_ctrl.sv
module bidsc_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  bidsc_pkg::t_dp_status i_status,
    output logic                  o_in_ready,
    output bidsc_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (i_status.op) inside
                    bidsc_pkg::OP_LOOKUP, bidsc_pkg::OP_REMOVE: begin
                        n_state = S_SCAN;
                    end
                    bidsc_pkg::OP_INSERT: begin
                        o_cmd.ins    = !i_status.full;
                        o_cmd.set_ok = !i_status.full;
                        n_state      = S_DONE;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_SCAN: begin
                o_cmd.issue = 1'b1;
                if (i_status.hit) begin
                    o_cmd.set_ok = 1'b1;
                    n_state = (i_status.op == bidsc_pkg::OP_REMOVE) ? S_SHIFT : S_DONE;
                end else if (i_status.drained) begin
                    n_state = S_DONE;
                end
            end
            S_SHIFT: begin
                o_cmd.issue = 1'b1;
                o_cmd.shift = 1'b1;
                if (i_status.drained) begin
                    o_cmd.dec = 1'b1;
                    n_state   = S_DONE;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

### rtl/bounded_id_set_with_compaction.sv
// Channel   Direction  Handshake                   Word
// input     in         i_in_valid / o_in_ready     i_in_data  (op, key)
// result    out        o_out_valid / i_out_ready   o_out_data (success, entry_count)
// config    in         i_cfg_we                    i_cfg_wdata (capacity)
//
// An insert or an unused code passes from dispatch to the done state, which registers
// its result. A lookup that misses and every remove read each stored entry, one entry a
// cycle through the single read port of the key store; a lookup that hits stops at its
// index. A word is accepted only in the idle state, after the last result is registered.
// Reset is synchronous and active low; it clears the count and sets the capacity to 64.
// A result that waits in the output register stalls the controller only at its last step.
module bounded_id_set_with_compaction #(
    parameter int unsigned DEPTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  bidsc_pkg::t_in_word           i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output bidsc_pkg::t_out_word          o_out_data,
    input  logic                          i_cfg_we,
    input  logic [bidsc_pkg::CNT_W-1:0]   i_cfg_wdata
);

    bidsc_pkg::t_dp_cmd    cmd;
    bidsc_pkg::t_dp_status status;

    bidsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    bidsc_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_ready (i_out_ready),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
